// ===== rtl/csv_field_tokenizer_core_macros.svh =====
// ----------------------------------------------------------------------------
// CSV tokenizer assertion macros
// Shared concurrent assertion forms, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_CORE_MACROS_SVH
`define CSV_FIELD_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication
`define CSVT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvt assertion failed");

// Next-cycle implication
`define CSVT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvt assertion failed");

`endif

// ===== rtl/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Byte constants, result codes, parser phases and the result struct.
// ----------------------------------------------------------------------------
package csvt_pkg;

    localparam logic [7:0] QUOTE_BYTE    = 8'h22;
    localparam logic [7:0] NEWLINE_BYTE  = 8'h0A;
    localparam logic [7:0] NUL_BYTE      = 8'h00;
    localparam logic [7:0] DEFAULT_SEP   = 8'h2C;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_ROW_END   = 2'd2
    } t_kind;

    // Parser phases, one-hot
    typedef enum logic [4:0] {
        PH_LINE_START  = 5'b00001,
        PH_FIELD_START = 5'b00010,
        PH_PLAIN       = 5'b00100,
        PH_QUOTED      = 5'b01000,
        PH_QUOTE_SEEN  = 5'b10000
    } t_phase;

    // One result from the parser
    typedef struct packed {
        logic       has;
        t_kind      kind;
        logic [7:0] data;
        logic [7:0] col;
    } t_result;

endpackage

// ===== rtl/csvt_parse.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer parser
// Phase and column state, plus the single-pass decode of one byte request.
// ----------------------------------------------------------------------------
module csvt_parse import csvt_pkg::*; #(
    parameter int MAX_COLUMN_INDEX = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_stream,
    input  logic [7:0] i_sep,
    output t_result    o_res
);

    `include "csv_field_tokenizer_core_macros.svh"

    localparam logic [7:0] COL_CAP =
        8'((MAX_COLUMN_INDEX < 255) ? MAX_COLUMN_INDEX : 255);

    t_phase     r_phase, n_phase;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] w_cnt;
    logic [7:0] w_cnt_inc;
    logic       w_end;
    logic       w_quote;
    logic       w_sep;

    assign w_end     = i_end_of_stream || (i_text_byte == NUL_BYTE)
                       || (i_text_byte == NEWLINE_BYTE);
    assign w_quote   = (i_text_byte == QUOTE_BYTE);
    assign w_sep     = (i_text_byte == i_sep);
    // line start forces column zero
    assign w_cnt     = (r_phase == PH_LINE_START) ? 8'd0 : r_cnt;
    assign w_cnt_inc = (w_cnt < COL_CAP) ? w_cnt + 8'd1 : w_cnt;

    // Next state and result
    always_comb begin
        n_phase    = r_phase;
        n_cnt      = w_cnt;
        o_res.has  = 1'b0;
        o_res.kind = KIND_DATA;
        o_res.data = 8'd0;
        o_res.col  = w_cnt;
        if (w_end) begin
            o_res.has  = (r_phase != PH_LINE_START);
            o_res.kind = KIND_ROW_END;
            o_res.col  = r_cnt;
            n_phase    = PH_LINE_START;
            n_cnt      = 8'd0;
        end else begin
            unique case (r_phase)
                PH_QUOTED: begin
                    if (w_quote) begin
                        n_phase = PH_QUOTE_SEEN;
                    end else begin
                        o_res.has  = 1'b1;
                        o_res.data = i_text_byte;
                    end
                end
                PH_QUOTE_SEEN, PH_PLAIN: begin
                    if (r_phase == PH_QUOTE_SEEN && w_quote) begin
                        // doubled quote gives one quote byte
                        n_phase    = PH_QUOTED;
                        o_res.has  = 1'b1;
                        o_res.data = QUOTE_BYTE;
                    end else if (w_sep) begin
                        o_res.has  = 1'b1;
                        o_res.kind = KIND_FIELD_END;
                        n_cnt      = w_cnt_inc;
                        n_phase    = PH_FIELD_START;
                    end else begin
                        n_phase    = PH_PLAIN;
                        o_res.has  = 1'b1;
                        o_res.data = i_text_byte;
                    end
                end
                default: begin
                    // field start, line start and unknown codes
                    if (w_quote) begin
                        n_phase = PH_QUOTED;
                    end else if (w_sep) begin
                        o_res.has  = 1'b1;
                        o_res.kind = KIND_FIELD_END;
                        n_cnt      = w_cnt_inc;
                        n_phase    = PH_FIELD_START;
                    end else begin
                        n_phase    = PH_PLAIN;
                        o_res.has  = 1'b1;
                        o_res.data = i_text_byte;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE_START;
            r_cnt   <= 8'd0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    `CSVT_ASSERT_NXT(a_row_end_clears, i_clk, i_rst_n, i_adv && w_end,
        r_phase == PH_LINE_START && r_cnt == 8'd0)
    `CSVT_ASSERT_IMP(a_cnt_capped, i_clk, i_rst_n, 1'b1, r_cnt <= COL_CAP)
    `CSVT_ASSERT_IMP(a_line_start_zero, i_clk, i_rst_n,
        r_phase == PH_LINE_START, r_cnt == 8'd0)
    `CSVT_ASSERT_IMP(a_marker_no_data, i_clk, i_rst_n,
        o_res.has && o_res.kind != KIND_DATA, o_res.data == 8'd0)

endmodule

// ===== rtl/csv_field_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer core
// Byte-serial CSV tokenizer: quoted fields, configurable separator, row flush.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      i_in_valid/o_in_stall  i_text_byte, i_end_of_stream
//  out       output     o_out_valid/i_out_stall o_item_kind, o_data_byte,
//                                              o_column_index
//  cfg       input      i_cfg_valid/o_cfg_ready i_separator_char
//
//  One byte request per cycle while the output is not stalled; each taken request
//  is decoded from the input register into the result register.
//  The phase/column update is set by the parser's decode.
//  Synchronous active-low reset: separator 0x2C, line start, column zero.
//  A stalled output holds the input register only for requests that yield a
//  result; requests with no result drain regardless.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_core import csvt_pkg::*; #(
    parameter int MAX_COLUMN_INDEX = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_stream,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_item_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_column_index,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_separator_char
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eos;
    logic [7:0] r_sep;
    logic       r_out_valid;
    t_kind      r_kind;
    logic [7:0] r_data;
    logic [7:0] r_col;
    t_result    w_res;
    logic       w_out_free;
    logic       w_adv;
    logic       w_in_acc;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_adv       = r_in_valid && (w_out_free || !w_res.has);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // Separator register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= DEFAULT_SEP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sep <= i_separator_char;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_text_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    csvt_parse #(
        .MAX_COLUMN_INDEX(MAX_COLUMN_INDEX)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_text_byte    (r_in_byte),
        .i_end_of_stream(r_in_eos),
        .i_sep          (r_sep),
        .o_res          (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_adv && w_res.has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.has) begin
            r_kind <= w_res.kind;
            r_data <= w_res.data;
            r_col  <= w_res.col;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_item_kind    = r_kind;
    assign o_data_byte    = r_data;
    assign o_column_index = r_col;

endmodule
